[src/positional_list_insert_remove_macros.svh]
// Assertion macros shared by the positional list RTL.
`ifndef POSITIONAL_LIST_INSERT_REMOVE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional list: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PLI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional list: next-cycle check failed");

`endif

[src/pli_pkg.sv]
// Types and codes for the positional list block.
package pli_pkg;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_WRITE_VAL,
      S_READ_WAIT
   } state_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [6:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [6:0]         element_count;
      logic [1:0]         status;
   } rsp_type;

endpackage

[src/positional_list_insert_remove.sv]
// Top level of the positional list: command sequencer around the element store.
//
//   channel   direction  handshake                    word
//   --------  ---------  ---------------------------  --------------------------
//   request   in         start && !busy               req_data (req_type)
//   response  out        rsp_strobe, one cycle        rsp_data (rsp_type)
//
// Every moved element takes a registered read and then a write on the element store,
// so the shift loop sets the rate. The response strobes in the cycle after the
// command's last cycle, when the next command may already be accepted.
// Reset clears the count and the sequencer; element contents are left as they are.
// The receiver cannot stall: rsp_strobe marks each response word for one cycle only.
module positional_list_insert_remove
   import pli_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

`include "positional_list_insert_remove_macros.svh"

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > 7) ? CW : 7) + 1;

   state_type          state_ff, state_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic signed [31:0] val_ff, val_in;
   logic [AW-1:0]      idx_ff, idx_in;   // destination of the next move
   logic [AW-1:0]      lim_ff, lim_in;   // where the shift loop stops
   logic [CW-1:0]      count_ff, count_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   // shared index unit: one step of the shift loop
   logic               is_ins;
   logic [AW-1:0]      nxt;

   // wide views for the range checks
   logic [CMPW-1:0]    pos_ext, pos_m1, cnt_ext, cnt_m1, cnt_p1;
   logic [AW-1:0]      ins_at;

   // store ports
   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic signed [31:0] wr_data, rd_data;

   // finishing a command
   logic               fin;
   status_type         fin_status;
   logic [CW-1:0]      fin_count;
   logic signed [31:0] fin_rd;

   pli_store #(
      .DEPTH(CAPACITY),
      .AW   (AW)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign is_ins  = (cmd_ff == CMD_INSERT);
   assign nxt     = is_ins ? (idx_ff - 1'b1) : (idx_ff + 1'b1);

   assign pos_ext = CMPW'(req_data.position);
   assign pos_m1  = pos_ext - 1'b1;
   assign cnt_ext = CMPW'(count_ff);
   assign cnt_m1  = cnt_ext - 1'b1;
   assign cnt_p1  = cnt_ext + 1'b1;
   // insert into an empty list lands first whatever the position
   assign ins_at  = (count_ff == '0) ? '0 : pos_m1[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
      lim_ff <= lim_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      val_in     = val_ff;
      idx_in     = idx_ff;
      lim_in     = lim_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = val_ff;
      rd_addr    = nxt;
      fin        = 1'b0;
      fin_status = ST_OK;
      fin_count  = count_ff;
      fin_rd     = '0;

      unique case (state_ff)
         S_IDLE: begin
            // fetch early so a read command has its word in the following cycle
            rd_addr = pos_m1[AW-1:0];
            if (start) begin
               cmd_in = req_data.command;
               val_in = req_data.value;
               unique case (req_data.command)
                  CMD_INSERT: begin
                     if (cnt_ext >= CMPW'(CAPACITY)) begin
                        fin        = 1'b1;
                        fin_status = ST_FULL;
                     end else if (count_ff == '0 ||
                                  (pos_ext != '0 && pos_ext <= cnt_p1)) begin
                        idx_in = count_ff[AW-1:0];
                        lim_in = ins_at;
                        if (count_ff[AW-1:0] > ins_at) begin
                           state_in = S_SHIFT_RD;
                        end else begin
                           state_in = S_WRITE_VAL;
                        end
                     end else begin
                        fin        = 1'b1;
                        fin_status = ST_RANGE;
                     end
                  end
                  CMD_REMOVE: begin
                     if (pos_ext != '0 && pos_ext <= cnt_ext) begin
                        idx_in = pos_m1[AW-1:0];
                        lim_in = cnt_m1[AW-1:0];
                        if (pos_m1 < cnt_m1) begin
                           state_in = S_SHIFT_RD;
                        end else begin
                           fin       = 1'b1;
                           fin_count = count_ff - 1'b1;
                        end
                     end else begin
                        fin        = 1'b1;
                        fin_status = ST_RANGE;
                     end
                  end
                  CMD_READ: begin
                     if (pos_ext != '0 && pos_ext <= cnt_ext) begin
                        state_in = S_READ_WAIT;
                     end else begin
                        fin        = 1'b1;
                        fin_status = ST_RANGE;
                     end
                  end
                  default: begin
                     // unused code: answer ok, change nothing
                     fin = 1'b1;
                  end
               endcase
            end
         end
         S_SHIFT_RD: begin
            rd_addr  = nxt;
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            // move the fetched neighbor into the current slot, advance
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data;
            idx_in  = nxt;
            if (is_ins) begin
               state_in = (nxt > lim_ff) ? S_SHIFT_RD : S_WRITE_VAL;
            end else if (nxt < lim_ff) begin
               state_in = S_SHIFT_RD;
            end else begin
               state_in  = S_IDLE;
               fin       = 1'b1;
               fin_count = count_ff - 1'b1;
            end
         end
         S_WRITE_VAL: begin
            wr_en     = 1'b1;
            wr_addr   = idx_ff;
            wr_data   = val_ff;
            state_in  = S_IDLE;
            fin       = 1'b1;
            fin_count = count_ff + 1'b1;
         end
         S_READ_WAIT: begin
            state_in = S_IDLE;
            fin      = 1'b1;
            fin_rd   = rd_data;
         end
      endcase

      count_in                = fin ? fin_count : count_ff;
      rsp_strobe_in           = fin;
      rsp_in                  = rsp_ff;
      if (fin) begin
         rsp_in.read_value    = fin_rd;
         rsp_in.element_count = 7'(CMPW'(fin_count));
         rsp_in.status        = fin_status;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `PLI_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `PLI_ASSERT_NOW(a_count_with_rsp, clock, reset, !$stable(count_ff), rsp_strobe_ff)
   `PLI_ASSERT_NOW(a_err_keeps_count, clock, reset,
                   rsp_strobe_ff && rsp_ff.status != ST_OK, $stable(count_ff))
   `PLI_ASSERT_NEXT(a_rd_then_wr, clock, reset, state_ff == S_SHIFT_RD, state_ff == S_SHIFT_WR)

endmodule

[src/pli_store.sv]
// Element store: one write port, one read port with registered read data.
module pli_store
   import pli_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic signed [31:0]  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output logic signed [31:0]  rd_data
);

   logic signed [31:0] mem_ff [DEPTH];
   logic signed [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[verif/testbench.sv]
// Self-checking testbench for the positional list: directed table, then random command bursts.
module testbench;
   import pli_pkg::*;

   localparam int LIST_CAPACITY = 64;
   localparam int RANDOM_ITEMS  = 900;
   // Worst busy time of one command is an insert at the head of a list one short of full.
   localparam int TAIL_CYCLES   = 2 * (LIST_CAPACITY + 1) + 70;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int MAX_REPORTS   = 10;

   // Command code the block must ignore; the package names only the three real ones.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Shape of a random phase: grow the list, shrink it, or mix freely.
   typedef enum int {
      PHASE_FILL,
      PHASE_DRAIN,
      PHASE_MIX
   } phase_type;

   // One row of the directed table; typed rows carry their own response word.
   typedef struct {
      req_type    word;
      bit         typed;
      rsp_type    rsp;
   } table_row_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Shadow copy of the list, advanced once per accepted request word.
   logic signed [31:0] shadow_elems [LIST_CAPACITY];
   int                 shadow_count = 0;

   rsp_type       due_rsp [$];
   table_row_type table_rows [$];
   int            fail_count = 0;

   // Sender pacing and random phase bookkeeping.
   int        burst_left = 0;
   phase_type phase     = PHASE_FILL;
   int        phase_left = 0;

   positional_list_insert_remove #(
      .CAPACITY  (LIST_CAPACITY)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs with busy high or never answers.
   initial begin
      #20_000_000;
      $display("FAIL positional_list_insert_remove");
      $finish;
   end

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   // Apply one request word to the shadow list and return the response word it yields.
   // Insert checks fullness first, then the empty-list case, then the position.
   function automatic rsp_type apply_to_shadow_list(input req_type w);
      rsp_type r;
      int      k;
      int      i;
      r = '0;
      r.status = ST_OK;
      k = int'(w.position);
      case (w.command)
         CMD_INSERT: begin
            if (shadow_count >= LIST_CAPACITY) begin
               r.status = ST_FULL;
            end else if (shadow_count == 0) begin
               // empty list: the value goes first whatever the position
               shadow_elems[0] = w.value;
               shadow_count = 1;
            end else if (k < 1 || k > shadow_count + 1) begin
               r.status = ST_RANGE;
            end else begin
               for (i = shadow_count; i >= k; i--) begin
                  shadow_elems[i] = shadow_elems[i - 1];
               end
               shadow_elems[k - 1] = w.value;
               shadow_count++;
            end
         end
         CMD_REMOVE: begin
            if (k < 1 || k > shadow_count) begin
               r.status = ST_RANGE;
            end else begin
               for (i = k - 1; i + 1 < shadow_count; i++) begin
                  shadow_elems[i] = shadow_elems[i + 1];
               end
               shadow_count--;
            end
         end
         CMD_READ: begin
            if (k < 1 || k > shadow_count) begin
               r.status = ST_RANGE;
            end else begin
               r.read_value = shadow_elems[k - 1];
            end
         end
         default: begin
            // unused code: leave the list alone, report ok
         end
      endcase
      r.element_count = 7'(shadow_count);
      return r;
   endfunction

   task automatic add_row(input logic [1:0] cmd, input int pos, input logic [31:0] val,
                          input bit typed, input logic [31:0] rd, input int cnt,
                          input status_type st);
      table_row_type row;
      row.word.command       = cmd;
      row.word.position      = 7'(pos);
      row.word.value         = val;
      row.typed              = typed;
      row.rsp.read_value     = rd;
      row.rsp.element_count  = 7'(cnt);
      row.rsp.status         = st;
      table_rows.push_back(row);
   endtask

   // Values with a bias toward the two's complement extremes.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Draw a position in 1..top, biased toward the ends; for top below 1, any of 0 to 65.
   function automatic int pick_position(input int top);
      if (top < 1) begin
         return $urandom_range(0, 65);
      end
      case ($urandom_range(0, 9))
         0:       return 1;
         1:       return top;
         default: return $urandom_range(1, top);
      endcase
   endfunction

   // Build the next random request word from the phase and the shadow fill level.
   function automatic req_type pick_word();
      req_type w;
      int      roll;
      int      ins_pct;
      int      rem_pct;
      case (phase)
         PHASE_FILL:  begin ins_pct = 80; rem_pct = 8;  end
         PHASE_DRAIN: begin ins_pct = 10; rem_pct = 75; end
         default:     begin ins_pct = 40; rem_pct = 35; end
      endcase
      roll = $urandom_range(0, 99);
      w.value = pick_value();
      if (roll < 2) begin
         w.command = CMD_UNUSED;
      end else if (roll < 2 + ins_pct) begin
         w.command = CMD_INSERT;
      end else if (roll < 2 + ins_pct + rem_pct) begin
         w.command = CMD_REMOVE;
      end else begin
         w.command = CMD_READ;
      end
      if ($urandom_range(0, 99) < 15) begin
         // noise: any position from 0 to 65, in range or not
         w.position = 7'($urandom_range(0, 65));
      end else if (w.command == CMD_INSERT) begin
         w.position = 7'(pick_position(shadow_count == 0 ? 0 : shadow_count + 1));
      end else begin
         w.position = 7'(pick_position(shadow_count));
      end
      return w;
   endfunction

   // Once a burst is used up, close it: drop start, put junk on the bus, idle a random stretch.
   task automatic pace_sender();
      int gap;
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         gap = $urandom_range(1, 4);
      end else if (roll < 95) begin
         gap = $urandom_range(5, 40);
      end else begin
         gap = $urandom_range(41, 160);
      end
      start    <= 1'b0;
      req_data <= req_type'({$urandom, $urandom});
      repeat (gap) @(posedge clock);
      // now and then hold a long stretch with no idling at all
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
   endtask

   // Present one request word, hold it until taken, then log the response it owes.
   task automatic send_word(input req_type w, input bit typed, input rsp_type typed_rsp);
      rsp_type r;
      req_data <= w;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = apply_to_shadow_list(w);
      due_rsp.push_back(typed ? typed_rsp : r);
   endtask

   // Response side: the block cannot be held off, so check every strobed word at once.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (due_rsp.size() == 0) begin
            report_failure($sformatf("response word with nothing due: rd=%h cnt=%0d st=%0d",
                                     rsp_data.read_value, rsp_data.element_count,
                                     rsp_data.status));
         end else begin
            want = due_rsp.pop_front();
            if (rsp_data.read_value !== want.read_value) begin
               report_failure($sformatf("read_value want %h got %h",
                                        want.read_value, rsp_data.read_value));
            end
            if (rsp_data.element_count !== want.element_count) begin
               report_failure($sformatf("element_count want %0d got %0d",
                                        want.element_count, rsp_data.element_count));
            end
            if (rsp_data.status !== want.status) begin
               report_failure($sformatf("status want %0d got %0d",
                                        want.status, rsp_data.status));
            end
         end
      end
   end

   initial begin : stimulus
      req_type w;
      rsp_type none;
      int      n;
      int      drain_wait;

      none = '0;

      // Directed table: empty list errors, insert anywhere into an empty list,
      // range limits on both ends, the unused code, append, head and tail removal.
      add_row(CMD_READ,   1,  32'h0,          1, 32'h0,          0, ST_RANGE);
      add_row(CMD_REMOVE, 0,  32'h0,          1, 32'h0,          0, ST_RANGE);
      add_row(CMD_REMOVE, 65, 32'hFFFF_FFFF,  1, 32'h0,          0, ST_RANGE);
      add_row(CMD_INSERT, 0,  32'h8000_0000,  1, 32'h0,          1, ST_OK);
      add_row(CMD_READ,   1,  32'h0,          1, 32'h8000_0000,  1, ST_OK);
      add_row(CMD_INSERT, 65, 32'h7,          1, 32'h0,          1, ST_RANGE);
      add_row(CMD_INSERT, 0,  32'h7,          1, 32'h0,          1, ST_RANGE);
      add_row(CMD_INSERT, 2,  32'h7FFF_FFFF,  1, 32'h0,          2, ST_OK);
      add_row(CMD_INSERT, 1,  32'hFFFF_FFFF,  1, 32'h0,          3, ST_OK);
      add_row(CMD_INSERT, 2,  32'h0,          0, 32'h0,          0, ST_OK);
      add_row(CMD_READ,   0,  32'h0,          1, 32'h0,          4, ST_RANGE);
      add_row(CMD_READ,   5,  32'h0,          1, 32'h0,          4, ST_RANGE);
      add_row(CMD_READ,   4,  32'h0,          0, 32'h0,          0, ST_OK);
      add_row(CMD_READ,   2,  32'h0,          0, 32'h0,          0, ST_OK);
      add_row(CMD_UNUSED, 65, 32'hAAAA_AAAA,  1, 32'h0,          4, ST_OK);
      add_row(CMD_INSERT, 5,  32'h1234_5678,  0, 32'h0,          0, ST_OK);
      add_row(CMD_INSERT, 64, 32'h1,          1, 32'h0,          5, ST_RANGE);
      add_row(CMD_REMOVE, 6,  32'h0,          1, 32'h0,          5, ST_RANGE);
      add_row(CMD_REMOVE, 5,  32'h0,          0, 32'h0,          0, ST_OK);
      add_row(CMD_REMOVE, 1,  32'h0,          0, 32'h0,          0, ST_OK);
      add_row(CMD_READ,   1,  32'h0,          0, 32'h0,          0, ST_OK);
      add_row(CMD_REMOVE, 2,  32'h0,          0, 32'h0,          0, ST_OK);
      add_row(CMD_REMOVE, 1,  32'h0,          0, 32'h0,          0, ST_OK);
      add_row(CMD_REMOVE, 1,  32'h0,          1, 32'h0,          0, ST_OK);
      add_row(CMD_INSERT, 64, 32'h5555_5555,  1, 32'h0,          1, ST_OK);

      // Hold reset, then release it once.
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (table_rows[r]) begin
         pace_sender();
         send_word(table_rows[r].word, table_rows[r].typed, table_rows[r].rsp);
      end

      // Random part: phases of filling, draining and mixing so the list
      // swings between empty and full and hits the full-list case repeatedly.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            phase      = phase_type'($urandom_range(0, 2));
            phase_left = $urandom_range(30, 120);
         end
         phase_left--;
         w = pick_word();
         pace_sender();
         send_word(w, 1'b0, none);
      end
      start <= 1'b0;

      // Wait out the last responses, then a tail for any stray word.
      drain_wait = 0;
      while (due_rsp.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (due_rsp.size() != 0) begin
         report_failure($sformatf("%0d response words never arrived", due_rsp.size()));
      end

      if (fail_count == 0) begin
         $display("PASS positional_list_insert_remove");
      end else begin
         $display("FAIL positional_list_insert_remove");
      end
      $finish;
   end

endmodule
